[rtl/core/utf8sd_pkg.sv]
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared widths, byte pattern constants and the lead byte classifier of the
// utf-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int OUT_TDATA_W = 24;
    localparam int QUEUE_DEPTH = 4;

    // lead byte patterns
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    // payload masks
    localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
    localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
    localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;
    localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

    // number of following bytes a lead byte asks for, zero for any other byte
    function automatic logic [1:0] lead_needs(input logic [7:0] b);
        logic [1:0] need;
        need = 2'd0;
        if (b < ASCII_LIMIT) begin
            need = 2'd0;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            need = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            need = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            need = 2'd3;
        end
        return need;
    endfunction

endpackage

[rtl/core/utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Turns a byte stream of utf-8 strings into code points, one code point per
// output transfer, with tlast on the final code point of each string.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)           | tlast
//  s_axis   | in  | [7:0] in_byte                | end_of_string
//  m_axis   | out | [20:0] code_point, [23:21] 0 | last_of_string
//
//  One byte is accepted per cycle while s_axis_tready is high; its code
//  points land in a four-entry result queue in the same cycle and leave
//  it one per cycle from the next while m_axis_tready is high. A byte that
//  closes a truncated string gives up to three; their drain bounds the rate.
//  s_axis_tready stays high while the queue holds at most one result after
//  this cycle's output transfer, so a stalled output does not stop input
//  at once. Synchronous active-low reset empties the queue and the held lead.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast
);

    typedef logic [3:0][7:0] t_bytes;

    typedef struct packed {
        logic [utf8sd_pkg::CP_W-1:0] cp;
        logic [2:0]                  used;
    } t_dec;

    typedef struct packed {
        logic [utf8sd_pkg::CP_W-1:0] cp;
        logic                        last;
    } t_res;

    // decode one code point starting at pos; len is the end of the string
    function automatic t_dec decode_at(input t_bytes bytes, input logic [2:0] pos,
                                       input logic [2:0] len);
        t_dec       d;
        logic [7:0] b0;
        logic [7:0] lead_pay;
        logic [7:0] cont;
        logic [1:0] need;
        logic [2:0] idx;
        b0   = bytes[pos[1:0]];
        need = utf8sd_pkg::lead_needs(b0);
        if (need == 2'd0 || (pos + {1'b0, need}) >= len) begin
            d.cp   = {{(utf8sd_pkg::CP_W-8){1'b0}}, b0};
            d.used = 3'd1;
        end else begin
            case (need)
                2'd1:    lead_pay = b0 & utf8sd_pkg::LEAD2_PAYLOAD;
                2'd2:    lead_pay = b0 & utf8sd_pkg::LEAD3_PAYLOAD;
                default: lead_pay = b0 & utf8sd_pkg::LEAD4_PAYLOAD;
            endcase
            d.cp = {{(utf8sd_pkg::CP_W-8){1'b0}}, lead_pay};
            for (int k = 1; k <= 3; k++) begin
                if (2'(k) <= need) begin
                    idx  = pos + 3'(k);
                    cont = bytes[idx[1:0]] & utf8sd_pkg::CONT_PAYLOAD;
                    d.cp = {d.cp[utf8sd_pkg::CP_W-7:0], cont[5:0]};
                end
            end
            d.used = {1'b0, need} + 3'd1;
        end
        return d;
    endfunction

    // sequence state
    logic [7:0] r_held [0:2];
    logic [7:0] n_held [0:2];
    logic [1:0] r_hc, n_hc;
    logic [1:0] r_need, n_need;

    // result queue
    t_res       r_q [0:utf8sd_pkg::QUEUE_DEPTH-1];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt, n_cnt;

    logic       pop, accept;
    logic [1:0] n_push;
    t_res       res [0:2];
    t_bytes     bytes;
    logic [2:0] len, p1, p2;
    t_dec       d0, d1, d2;
    logic [1:0] need_b;

    assign pop           = (r_cnt != 3'd0) && m_axis_tready;
    assign s_axis_tready = (r_cnt - {2'b00, pop}) <= 3'd1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = {{(utf8sd_pkg::OUT_TDATA_W-utf8sd_pkg::CP_W){1'b0}},
                            r_q[r_rd].cp};
    assign m_axis_tlast  = r_q[r_rd].last;

    always_comb begin
        bytes[0] = (r_hc > 2'd0) ? r_held[0] : ((r_hc == 2'd0) ? s_axis_tdata : 8'h00);
        bytes[1] = (r_hc > 2'd1) ? r_held[1] : ((r_hc == 2'd1) ? s_axis_tdata : 8'h00);
        bytes[2] = (r_hc > 2'd2) ? r_held[2] : ((r_hc == 2'd2) ? s_axis_tdata : 8'h00);
        bytes[3] = (r_hc == 2'd3) ? s_axis_tdata : 8'h00;
        len      = {1'b0, r_hc} + 3'd1;
        need_b   = utf8sd_pkg::lead_needs(s_axis_tdata);

        // chained decodes for the end of a string
        d0 = decode_at(bytes, 3'd0, len);
        p1 = d0.used;
        d1 = decode_at(bytes, p1, len);
        p2 = p1 + d1.used;
        d2 = decode_at(bytes, p2, len);

        n_held = r_held;
        n_hc   = r_hc;
        n_need = r_need;
        n_push = 2'd0;
        res[0] = '{cp: d0.cp, last: 1'b0};
        res[1] = '{cp: d1.cp, last: 1'b0};
        res[2] = '{cp: d2.cp, last: 1'b1};

        if (accept) begin
            if (s_axis_tlast) begin
                n_hc   = 2'd0;
                n_need = 2'd0;
                if (p1 >= len) begin
                    n_push      = 2'd1;
                    res[0].last = 1'b1;
                end else if (p2 >= len) begin
                    n_push      = 2'd2;
                    res[1].last = 1'b1;
                end else begin
                    n_push = 2'd3;
                end
            end else if (r_hc == 2'd0) begin
                if (need_b == 2'd0) begin
                    n_push = 2'd1;
                end else begin
                    n_held[0] = s_axis_tdata;
                    n_hc      = 2'd1;
                    n_need    = need_b;
                end
            end else if (r_hc >= r_need) begin
                // sequence complete
                n_push = 2'd1;
                n_hc   = 2'd0;
                n_need = 2'd0;
            end else begin
                n_held[r_hc] = s_axis_tdata;
                n_hc         = r_hc + 2'd1;
            end
        end

        n_cnt = r_cnt + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < n_push) begin
                r_q[r_wr + 2'(j)] <= res[j];
            end
        end
        if (!i_rst_n) begin
            r_hc   <= 2'd0;
            r_need <= 2'd0;
            r_cnt  <= 3'd0;
            r_wr   <= 2'd0;
            r_rd   <= 2'd0;
        end else begin
            r_hc   <= n_hc;
            r_need <= n_need;
            r_cnt  <= n_cnt;
            r_wr   <= r_wr + n_push;
            r_rd   <= r_rd + {1'b0, pop};
        end
    end

endmodule

[rtl/core/utf8sd_checker.sv]
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks on the utf-8 stream decoder, bound to its top level.
// ----------------------------------------------------------------------------
module utf8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a held result keeps its value until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // code points never exceed the 21-bit range
    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[utf8sd_pkg::OUT_TDATA_W-1:utf8sd_pkg::CP_W] == '0)
        else $error("padding bits of code point set");

    // input only backs off while results are queued
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result queue");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_utf8sd_checker (.*);
